// ----- hdl/tifs_pkg.sv -----
`default_nettype none
package tifs_pkg;

    // field widths
    localparam int OPCODE_W  = 1;
    localparam int BYTE_W    = 8;
    localparam int ITEM_ID_W = 12;
    localparam int RANK_W    = 6;
    localparam int ENTRY_W   = 8;
    localparam int STEP_W    = $clog2(RANK_W);

    // configuration port
    localparam int PART_ID_W  = 8;
    localparam int PART_CNT_W = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PART_ID    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PART_COUNT = 2'd1;

    // defaults for the top level parameters
    localparam int ITEM_IDS_DEF  = 4096;
    localparam int NUM_RANKS_DEF = 64;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_TEXT = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b1;

    // text constants
    localparam logic [BYTE_W-1:0] CHAR_0  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_NL = 8'h0A;
    localparam int DEC_BASE = 10;

    // table entry layout
    localparam int ENTRY_VALID_BIT = 7;
    localparam int ENTRY_SEL_BIT   = 6;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [BYTE_W-1:0]    text_byte;
        logic [ITEM_ID_W-1:0] item_id;
        logic [RANK_W-1:0]    rank;
    } t_in_req;

    typedef struct packed {
        logic [RANK_W-1:0] out_rank;
        logic              last;
    } t_out_rsp;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic div_step;
        logic tbl_wr;
        logic lookup_apply;
        logic line_clear;
        logic drain_init;
        logic drain_step;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_load;
        logic is_digit;
        logic is_nl;
        logic in_number;
        logic div_last;
        logic nl_pending;
        logic line_hit;
        logic drain_fin;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- hdl/tifs_ctrl.sv -----
`default_nettype none
module tifs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire tifs_pkg::t_dp_sts i_sts,
    output tifs_pkg::t_ctl_cmd     o_cmd,
    output logic                   o_in_ready
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_LOOKUP = 3'd4;
    localparam logic [2:0] S_LINE   = 3'd5;
    localparam logic [2:0] S_DRAIN  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.is_load) begin
                        n_state = S_DIV;
                    end else if (!i_sts.is_digit) begin
                        if (i_sts.in_number) begin
                            n_state = S_LOOKUP;
                        end else if (i_sts.is_nl) begin
                            n_state = S_LINE;
                        end
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.tbl_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_LOOKUP: begin
                o_cmd.lookup_apply = 1'b1;
                n_state = i_sts.nl_pending ? S_LINE : S_IDLE;
            end
            S_LINE: begin
                if (i_sts.line_hit) begin
                    o_cmd.drain_init = 1'b1;
                    n_state          = S_DRAIN;
                end else begin
                    o_cmd.line_clear = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_DRAIN: begin
                o_cmd.drain_step = 1'b1;
                if (i_sts.drain_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("controller issued more than one command");

endmodule
`default_nettype wire

// ----- hdl/tifs_datapath.sv -----
`default_nettype none
module tifs_datapath #(
    parameter int ITEM_IDS  = tifs_pkg::ITEM_IDS_DEF,
    parameter int NUM_RANKS = tifs_pkg::NUM_RANKS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tifs_pkg::t_in_req                   i_in_data,
    input  wire logic                                i_out_ready,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [tifs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [tifs_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    input  wire tifs_pkg::t_ctl_cmd                  i_cmd,
    output tifs_pkg::t_dp_sts                        o_sts,
    output logic                                     o_out_valid,
    output tifs_pkg::t_out_rsp                       o_out_data
);

    localparam int AW    = $clog2(ITEM_IDS);
    localparam int ACC_W = $clog2(ITEM_IDS + 1);
    localparam int MUL_W = ACC_W + 4;
    localparam int RW    = $clog2(NUM_RANKS);
    localparam int RANK_W = tifs_pkg::RANK_W;
    localparam int ENTRY_W = tifs_pkg::ENTRY_W;
    localparam int REM_W = tifs_pkg::PART_CNT_W;
    localparam int STEP_W = tifs_pkg::STEP_W;
    localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(ITEM_IDS);

    logic [ENTRY_W-1:0] mem [ITEM_IDS];

    // configuration
    logic [tifs_pkg::PART_ID_W-1:0]  r_part_id;
    logic [tifs_pkg::PART_CNT_W-1:0] r_part_count;

    // control state
    logic [AW-1:0]        r_clr_addr;
    logic [ACC_W-1:0]     r_acc,       n_acc;
    logic                 r_in_number, n_in_number;
    logic [NUM_RANKS-1:0] r_bitmap,    n_bitmap;
    logic                 r_line_sel,  n_line_sel;
    logic [RW-1:0]        r_idx,       n_idx;
    logic [STEP_W-1:0]    r_step;
    logic                 r_out_valid, n_out_valid;

    // payload
    logic [AW-1:0]      r_load_addr;
    logic [RANK_W-1:0]  r_load_rank;
    logic               r_load_ok;
    logic [RANK_W-1:0]  r_div_bits;
    logic [REM_W-1:0]   r_rem;
    logic               r_nl_pending;
    logic [ENTRY_W-1:0] r_rd_data;
    tifs_pkg::t_out_rsp r_out_data;

    logic                is_digit;
    logic                is_nl;
    logic                is_load;
    logic [MUL_W-1:0]    acc_next;
    logic                acc_in_range;
    logic [REM_W:0]      div_trial;
    logic                div_ge;
    logic [REM_W-1:0]    rem_next;
    logic                sel;
    logic [ENTRY_W-1:0]  entry;
    logic                bit_set;
    logic                slot_free;
    logic [NUM_RANKS-1:0] bitmap_rest;
    logic                drain_last;
    logic                out_load;

    assign is_load  = (i_in_data.opcode == tifs_pkg::OP_LOAD);
    assign is_digit = (i_in_data.text_byte >= tifs_pkg::CHAR_0)
                   && (i_in_data.text_byte <= tifs_pkg::CHAR_9);
    assign is_nl    = (i_in_data.text_byte == tifs_pkg::CHAR_NL);

    assign acc_next = MUL_W'(r_acc) * MUL_W'(tifs_pkg::DEC_BASE)
                    + MUL_W'(i_in_data.text_byte - tifs_pkg::CHAR_0);
    assign acc_in_range = (r_acc < ACC_MAX);

    // restoring remainder, one rank bit per step, msb first
    assign div_trial = {r_rem, r_div_bits[RANK_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_part_count});
    assign rem_next  = div_ge ? REM_W'(div_trial - {1'b0, r_part_count})
                              : REM_W'(div_trial);

    assign sel   = (r_part_count != '0) && (r_rem == REM_W'(r_part_id));
    assign entry = {1'b1, sel, r_load_rank};

    assign bit_set   = r_bitmap[r_idx];
    assign slot_free = !r_out_valid || i_out_ready;
    assign out_load  = i_cmd.drain_step && bit_set && slot_free;

    always_comb begin
        bitmap_rest        = r_bitmap;
        bitmap_rest[r_idx] = 1'b0;
    end
    assign drain_last = (bitmap_rest == '0);

    always_comb begin
        n_acc       = r_acc;
        n_in_number = r_in_number;
        n_bitmap    = r_bitmap;
        n_line_sel  = r_line_sel;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.accept && !is_load && is_digit) begin
            n_acc       = (acc_next > MUL_W'(ITEM_IDS)) ? ACC_MAX : ACC_W'(acc_next);
            n_in_number = 1'b1;
        end

        if (i_cmd.lookup_apply) begin
            if (acc_in_range && r_rd_data[tifs_pkg::ENTRY_VALID_BIT]) begin
                n_bitmap[r_rd_data[RW-1:0]] = 1'b1;
                if (r_rd_data[tifs_pkg::ENTRY_SEL_BIT]) begin
                    n_line_sel = 1'b1;
                end
            end
            n_acc       = '0;
            n_in_number = 1'b0;
        end

        if (i_cmd.line_clear) begin
            n_bitmap   = '0;
            n_line_sel = 1'b0;
        end

        if (i_cmd.drain_init) begin
            n_idx      = '0;
            n_line_sel = 1'b0;
        end

        if (i_cmd.drain_step && (!bit_set || slot_free)) begin
            n_idx = r_idx + 1'b1;
        end

        if (out_load) begin
            n_bitmap    = bitmap_rest;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_id    <= '0;
            r_part_count <= tifs_pkg::PART_CNT_W'(1);
            r_clr_addr   <= '0;
            r_acc        <= '0;
            r_in_number  <= 1'b0;
            r_bitmap     <= '0;
            r_line_sel   <= 1'b0;
            r_idx        <= '0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    tifs_pkg::CFG_PART_ID: begin
                        r_part_id <= i_cfg_wr_data[tifs_pkg::PART_ID_W-1:0];
                    end
                    tifs_pkg::CFG_PART_COUNT: begin
                        r_part_count <= i_cfg_wr_data[tifs_pkg::PART_CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.accept) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
            r_acc       <= n_acc;
            r_in_number <= n_in_number;
            r_bitmap    <= n_bitmap;
            r_line_sel  <= n_line_sel;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_load_addr  <= AW'(i_in_data.item_id);
            r_load_rank  <= i_in_data.rank;
            r_load_ok    <= (32'(i_in_data.item_id) < ITEM_IDS)
                         && (32'(i_in_data.rank) < NUM_RANKS);
            r_div_bits   <= i_in_data.rank;
            r_rem        <= '0;
            r_nl_pending <= is_nl;
        end else if (i_cmd.div_step) begin
            r_rem      <= rem_next;
            r_div_bits <= {r_div_bits[RANK_W-2:0], 1'b0};
        end
        if (out_load) begin
            r_out_data.out_rank <= RANK_W'(r_idx);
            r_out_data.last     <= drain_last;
        end
    end

    // rank table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.tbl_wr && r_load_ok) begin
            mem[r_load_addr] <= entry;
        end
        if (i_cmd.accept && acc_in_range) begin
            r_rd_data <= mem[AW'(r_acc)];
        end
    end

    assign o_sts.clr_done   = (r_clr_addr == AW'(ITEM_IDS - 1));
    assign o_sts.is_load    = is_load;
    assign o_sts.is_digit   = is_digit;
    assign o_sts.is_nl      = is_nl;
    assign o_sts.in_number  = r_in_number;
    assign o_sts.div_last   = (r_step == STEP_W'(RANK_W - 1));
    assign o_sts.nl_pending = r_nl_pending;
    assign o_sts.line_hit   = r_line_sel && (r_bitmap != '0);
    assign o_sts.drain_fin  = bit_set && slot_free && drain_last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= ACC_MAX)
        else $error("id accumulator above saturation value");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && drain_last) |=> (r_bitmap == '0))
        else $error("bitmap not empty after last rank of the line");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_out_valid) |-> i_out_ready)
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- hdl/transaction_item_filter_sorter_unit.sv -----
// one request at a time: in ready is high only while idle, so a new request waits for the last.
// load: the bit-serial remainder unit, one rank bit per step, then the table write; digit or other
// byte: taken in idle, plus a table lookup when it ends an id; newline: that lookup when it ends an
// id, then a line check, and for a selected line a scan of one bitmap bit per cycle up to the highest
// set rank, stalling while the output register is full. reset: synchronous active-low; then the
// rank table is cleared one entry per cycle, in ready low; configuration writes are taken throughout
`default_nettype none
module transaction_item_filter_sorter_unit #(
    parameter int ITEM_IDS  = tifs_pkg::ITEM_IDS_DEF,
    parameter int NUM_RANKS = tifs_pkg::NUM_RANKS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire tifs_pkg::t_in_req               i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output tifs_pkg::t_out_rsp                   o_out_data,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [tifs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [tifs_pkg::CFG_DATA_W-1:0] i_cfg_wr_data
);

    tifs_pkg::t_ctl_cmd cmd;
    tifs_pkg::t_dp_sts  sts;

    tifs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    tifs_datapath #(
        .ITEM_IDS  (ITEM_IDS),
        .NUM_RANKS (NUM_RANKS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_out_ready   (i_out_ready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule
`default_nettype wire
